// ----- hdl/dep_pkg.sv -----
// Shared types, codes and format lookup for the encoded pointer decoder.
`default_nettype none
package dep_pkg;

  localparam logic [7:0] ENC_OMIT   = 8'hff;
  localparam logic [7:0] APP_MASK   = 8'h70;
  localparam logic [7:0] FMT_MASK   = 8'h0f;
  localparam logic [6:0] LEB_PAYLOAD = 7'h7f;
  localparam int         LEB_MORE_BIT = 7;
  localparam int         LEB_SIGN_BIT = 6;

  localparam logic [2:0] APP_ABS   = 3'h0;
  localparam logic [2:0] APP_PCREL = 3'h1;

  localparam logic [3:0] FMT_PTR    = 4'h0;
  localparam logic [3:0] FMT_ULEB   = 4'h1;
  localparam logic [3:0] FMT_UDATA2 = 4'h2;
  localparam logic [3:0] FMT_UDATA4 = 4'h3;
  localparam logic [3:0] FMT_UDATA8 = 4'h4;
  localparam logic [3:0] FMT_SLEB   = 4'h9;
  localparam logic [3:0] FMT_SDATA2 = 4'ha;
  localparam logic [3:0] FMT_SDATA4 = 4'hb;
  localparam logic [3:0] FMT_SDATA8 = 4'hc;

  localparam logic       KIND_START = 1'b0;
  localparam logic       KIND_DATA  = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_OMIT    = 2'd1;
  localparam logic [1:0] ST_BAD_APP = 2'd2;
  localparam logic [1:0] ST_BAD_FMT = 2'd3;

  localparam logic [6:0] SHIFT_LIMIT = 7'd64;
  localparam logic [7:0] COUNT_MAX   = 8'hff;

  typedef struct packed {
    logic        known;
    logic        leb;
    logic        sgn;
    logic [3:0]  size;   // bytes, fixed formats only
  } fmt_info_t;

  typedef struct packed {
    logic        busy;
    logic [7:0]  encoding;
    logic [63:0] base;
    logic [63:0] acc;
    logic [6:0]  shift;
    logic [7:0]  count;
    logic        bad_app;
  } dec_state_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  encoding;
    logic [63:0] position;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic        valid;
    logic [63:0] value;
    logic [1:0]  status;
    logic [7:0]  bytes_used;
  } result_t;

  function automatic fmt_info_t fmt_lookup(input logic [3:0] fmt);
    fmt_info_t f;
    f = '0;
    case (fmt) inside
      FMT_PTR, FMT_UDATA8: begin f.known = 1'b1; f.size = 4'd8; end
      FMT_SDATA8:          begin f.known = 1'b1; f.size = 4'd8; f.sgn = 1'b1; end
      FMT_UDATA2:          begin f.known = 1'b1; f.size = 4'd2; end
      FMT_SDATA2:          begin f.known = 1'b1; f.size = 4'd2; f.sgn = 1'b1; end
      FMT_UDATA4:          begin f.known = 1'b1; f.size = 4'd4; end
      FMT_SDATA4:          begin f.known = 1'b1; f.size = 4'd4; f.sgn = 1'b1; end
      FMT_ULEB, FMT_SLEB:  begin f.known = 1'b1; f.leb = 1'b1; end
      default:             f = '0;
    endcase
    return f;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/dep_step.sv -----
// Per-item decode step: next decoder state and optional result for one item.
`default_nettype none
module dep_step (
  input  wire  dep_pkg::in_item_t   item,
  input  wire  dep_pkg::dec_state_t cur,
  output dep_pkg::dec_state_t       nxt,
  output dep_pkg::result_t          res
);
  import dep_pkg::*;

  fmt_info_t   start_fmt;
  fmt_info_t   held_fmt;
  logic [2:0]  start_app;
  logic [63:0] fix_acc;
  logic [6:0]  fix_shift;
  logic        fix_done;
  logic [63:0] leb_acc;
  logic [6:0]  leb_shift;
  logic        leb_done;
  logic [7:0]  count_inc;

  always_comb begin
    start_fmt = fmt_lookup(item.encoding[3:0]);
    held_fmt  = fmt_lookup(cur.encoding[3:0]);
    start_app = item.encoding[6:4];
    count_inc = (cur.count != COUNT_MAX) ? cur.count + 8'd1 : cur.count;

    // Fixed-size little-endian field: one byte per item.
    fix_acc   = cur.acc | ({56'b0, item.data_byte} << cur.shift[5:0]);
    fix_shift = cur.shift + 7'd8;
    fix_done  = fix_shift >= {held_fmt.size, 3'b000};
    if (held_fmt.sgn) begin
      case (held_fmt.size)
        4'd2:    if (fix_acc[15]) fix_acc[63:16] = '1;
        4'd4:    if (fix_acc[31]) fix_acc[63:32] = '1;
        default: ;
      endcase
    end

    // LEB128 field: seven payload bits per item, drop bits past 64.
    leb_acc   = cur.acc;
    leb_shift = cur.shift;
    if (cur.shift < SHIFT_LIMIT) begin
      leb_acc   = cur.acc | ({57'b0, item.data_byte[6:0] & LEB_PAYLOAD} << cur.shift[5:0]);
      leb_shift = cur.shift + 7'd7;
    end
    leb_done = !item.data_byte[LEB_MORE_BIT];
    // Sign fill only on the final byte of a signed LEB field.
    if (leb_done && cur.encoding[3:0] == FMT_SLEB && item.data_byte[LEB_SIGN_BIT]
        && leb_shift < SHIFT_LIMIT) begin
      leb_acc = leb_acc | ({64{1'b1}} << leb_shift[5:0]);
    end

    nxt = cur;
    res = '0;
    if (item.kind == KIND_START) begin
      nxt.busy     = 1'b0;
      nxt.acc      = '0;
      nxt.shift    = '0;
      nxt.count    = '0;
      nxt.encoding = item.encoding;
      if (item.encoding == ENC_OMIT) begin
        nxt.base    = '0;
        nxt.bad_app = 1'b0;
        res.valid   = 1'b1;
        res.status  = ST_OMIT;
      end else begin
        nxt.base    = (start_app == APP_PCREL) ? item.position : 64'd0;
        nxt.bad_app = (start_app != APP_ABS) && (start_app != APP_PCREL);
        if (!start_fmt.known) begin
          res.valid  = 1'b1;
          res.value  = nxt.base;
          res.status = ST_BAD_FMT;
        end else begin
          nxt.busy = 1'b1;
        end
      end
    end else if (cur.busy) begin
      nxt.count = count_inc;
      if (held_fmt.leb) begin
        nxt.acc   = leb_acc;
        nxt.shift = leb_shift;
      end else begin
        nxt.acc   = fix_acc;
        nxt.shift = fix_shift;
      end
      if (held_fmt.leb ? leb_done : fix_done) begin
        nxt.busy       = 1'b0;
        res.valid      = 1'b1;
        res.value      = cur.base + nxt.acc;
        res.status     = cur.bad_app ? ST_BAD_APP : ST_OK;
        res.bytes_used = count_inc;
      end
    end
  end

endmodule
`default_nettype wire

// ----- hdl/dwarf_encoded_pointer_decoder.sv -----
// Top level of the DWARF exception-header encoded pointer decoder.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall  kind, encoding, position, data_byte
//   out_     output     out_valid/out_stall  value, status, bytes_used
//
// One item per cycle sustained while the output does not stall: each item
// is registered, passes one decode step (byte shift/OR, sign fill, 64-bit
// base add) and lands in the result register, so a result is offered from
// the result register once its item has passed through the input register.
// Synchronous active-low reset clears both valid flags and decoder state.
// A stalled result holds; the input register takes one more item and, once
// it is full behind the stalled result, in_stall rises.
`default_nettype none
module dwarf_encoded_pointer_decoder (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire                in_kind,
  input  wire         [7:0]  in_encoding,
  input  wire         [63:0] in_position,
  input  wire         [7:0]  in_data_byte,
  output logic               out_valid,
  input  wire                out_stall,
  output logic signed [63:0] out_value,
  output logic        [1:0]  out_status,
  output logic        [7:0]  out_bytes_used
);
  import dep_pkg::*;

  logic       in_valid_r;
  in_item_t   in_item_r;
  dec_state_t state_r;
  dec_state_t state_nxt;
  result_t    step_res;
  logic       out_valid_r;
  logic [63:0] out_value_r;
  logic [1:0]  out_status_r;
  logic [7:0]  out_bytes_used_r;
  logic       out_free;
  logic       advance;
  logic       in_take;

  // Result register may load when empty or being drained this cycle.
  assign out_free = !out_valid_r || !out_stall;
  // Process the held item when the result side has room.
  assign advance  = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  dep_step u_step (
    .item (in_item_r),
    .cur  (state_r),
    .nxt  (state_nxt),
    .res  (step_res)
  );

  // Input register: load on accept, drop when consumed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r.kind      <= in_kind;
      in_item_r.encoding  <= in_encoding;
      in_item_r.position  <= in_position;
      in_item_r.data_byte <= in_data_byte;
    end
  end

  // Decoder state: advance once per processed item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // Result register: load a new result, else clear when taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= advance && step_res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step_res.valid) begin
      out_value_r      <= step_res.value;
      out_status_r     <= step_res.status;
      out_bytes_used_r <= step_res.bytes_used;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_value      = $signed(out_value_r);
  assign out_status     = out_status_r;
  assign out_bytes_used = out_bytes_used_r;

  // An omitted pointer reports zero value and no bytes.
  a_omit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == ST_OMIT |-> out_value_r == 64'd0
      && out_bytes_used_r == 8'd0)
    else $error("omit result not zero");

  // Results reached through data bytes consumed at least one byte.
  a_bytes_seen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r == ST_OK || out_status_r == ST_BAD_APP)
      |-> out_bytes_used_r != 8'd0)
    else $error("decoded result with zero bytes");

  // LEB shift never grows past one step beyond 64 bits.
  a_shift_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.shift <= 7'd70)
    else $error("bit shift out of range");

  // A held result waiting on the consumer stalls the input register once full.
  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && out_valid_r && out_stall |=> in_valid_r && $stable(state_r))
    else $error("item processed while result stalled");

endmodule
`default_nettype wire
